/* design/mexp_pkg.sv */
`timescale 1ns / 1ps
package mexp_pkg;

  localparam int OPERAND_BITS_DEF = 1024;
  localparam int WORD_BITS_DEF    = 64;
  localparam int DATA_W           = 64;
  localparam int IDX_W            = 4;
  localparam int CMD_W            = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LD_MOD  = 2'd0,
    CMD_LD_BASE = 2'd1,
    CMD_LD_EXP  = 2'd2,
    CMD_START   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_COPY = 5'b00100,
    ST_EXP  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // purpose of the running modular product
  typedef enum logic [1:0] {
    OP_BASE = 2'd0,
    OP_ONE  = 2'd1,
    OP_SQR  = 2'd2,
    OP_MULB = 2'd3
  } op_t;

  // which partial value of the accumulator ring is the reduced one
  typedef enum logic [1:0] {
    SEL_T  = 2'd0,
    SEL_D1 = 2'd1,
    SEL_D2 = 2'd2
  } sel_t;

  typedef struct packed {
    logic en;
    logic first;
    logic xbit;
  } alu_ctl_t;

endpackage

/* design/mexp_cell.sv */
`timescale 1ns / 1ps
module mexp_cell #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic [W-1:0] din,
  input  logic         ld,
  input  logic [W-1:0] ld_data,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ld) begin
      q <= ld_data;
    end else if (shift) begin
      q <= din;
    end
  end

endmodule

/* design/mexp_alu.sv */
`timescale 1ns / 1ps
module mexp_alu import mexp_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  alu_ctl_t     ctl,
  input  logic [W-1:0] r_word,
  input  logic [W-1:0] b_word,
  input  logic [W-1:0] m_word,
  output logic [W-1:0] t_word,
  output logic [W-1:0] d1_word,
  output logic [W-1:0] d2_word,
  output sel_t         sel_out
);

  logic       c1, b1, b2, rprev, mprev;
  logic       c1_next, b1_next, b2_next;
  logic       rp, mp, cc, bb1, bb2;
  logic [W:0] sum1, diff1, diff2;
  logic [1:0] top, sub2;
  logic       d1_ok, d2_ok;

  always_comb begin
    rp   = ctl.first ? 1'b0 : rprev;
    mp   = ctl.first ? 1'b0 : mprev;
    cc   = ctl.first ? 1'b0 : c1;
    bb1  = ctl.first ? 1'b0 : b1;
    bb2  = ctl.first ? 1'b0 : b2;
    // word of 2R + x*B
    sum1 = {1'b0, r_word[W-2:0], rp} + (ctl.xbit ? {1'b0, b_word} : '0) + {{W{1'b0}}, cc};
    t_word  = sum1[W-1:0];
    c1_next = sum1[W];
    diff1 = {1'b0, t_word} - {1'b0, m_word} - {{W{1'b0}}, bb1};
    diff2 = {1'b0, t_word} - {1'b0, m_word[W-2:0], mp} - {{W{1'b0}}, bb2};
    d1_word = diff1[W-1:0];
    d2_word = diff2[W-1:0];
    b1_next = diff1[W];
    b2_next = diff2[W];
    // bits above the top word, valid on the last word of a pass
    top   = {1'b0, r_word[W-1]} + {1'b0, c1_next};
    sub2  = {1'b0, m_word[W-1]} + {1'b0, b2_next};
    d1_ok = !((top == 2'd0) && b1_next);
    d2_ok = (top >= sub2);
    sel_out = d2_ok ? SEL_D2 : (d1_ok ? SEL_D1 : SEL_T);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1    <= 1'b0;
      b1    <= 1'b0;
      b2    <= 1'b0;
      rprev <= 1'b0;
      mprev <= 1'b0;
    end else if (ctl.en) begin
      c1    <= c1_next;
      b1    <= b1_next;
      b2    <= b2_next;
      rprev <= r_word[W-1];
      mprev <= m_word[W-1];
    end
  end

endmodule

/* design/modular_exponentiation_unit.sv */
`timescale 1ns / 1ps
// Operation: two setup products, then the squarings and one product per set exponent bit,
//   then the result words; each product shifts in one multiplier bit per pass over the
//   NWORDS words of the ring, followed by a copy pass.
// Throughput: one start at a time; busy stays high until the last result word is out.
// Results: NWORDS words on consecutive cycles marked by valid; the receiver cannot stall.
// A zero modulus emits zero words with error set, the first word in the cycle after the
// start transfer.
// Reset (synchronous, rst high) clears control state and the modulus, base and exponent stores.
module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  command,
  input  logic [IDX_W-1:0]  word_index,
  input  logic [DATA_W-1:0] word_data,
  output logic              valid,
  output logic [IDX_W-1:0]  result_index,
  output logic [DATA_W-1:0] result_data,
  output logic              last,
  output logic              error
);

  localparam int W      = WORD_BITS;
  localparam int NWORDS = OPERAND_BITS / WORD_BITS;
  localparam int WCW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SCW    = $clog2(OPERAND_BITS);
  localparam int ECW    = $clog2(OPERAND_BITS) + 1;

  state_t state;
  op_t    op;
  sel_t   sel;
  logic [WCW-1:0] wcnt;
  logic [SCW-1:0] scnt;
  logic [ECW-1:0] ecnt;
  logic [OPERAND_BITS-1:0] xreg, ereg, br;
  logic [W-1:0] rf [NWORDS];
  logic [W-1:0] base_st [NWORDS];
  logic [W-1:0] exp_st [NWORDS];
  logic zero, started, ebit, err;

  logic [3*W-1:0] acc_q [NWORDS];
  logic [W-1:0]   b_q [NWORDS];
  logic [W-1:0]   m_q [NWORDS];
  logic [3*W-1:0] acc_feed;
  logic [W-1:0]   b_feed, r_word, t_word, d1_word, d2_word;
  logic acc_shift, b_shift, m_shift, b_ld_one, mzero, wlast, go_mul, idle_xfer;
  op_t  go_op;
  sel_t alu_sel;
  alu_ctl_t ctl;

  assign idle_xfer = start && (state == ST_IDLE);
  assign wlast     = (wcnt == WCW'(NWORDS - 1));

  always_comb begin
    mzero = 1'b1;
    for (int k = 0; k < NWORDS; k++) begin
      if (m_q[k] != '0) mzero = 1'b0;
    end
  end

  always_comb begin
    if (zero) begin
      r_word = '0;
    end else begin
      case (sel)
        SEL_T:   r_word = acc_q[0][3*W-1:2*W];
        SEL_D1:  r_word = acc_q[0][2*W-1:W];
        SEL_D2:  r_word = acc_q[0][W-1:0];
        default: r_word = acc_q[0][3*W-1:2*W];
      endcase
    end
  end

  always_comb begin
    go_mul = 1'b0;
    go_op  = OP_BASE;
    case (state)
      ST_IDLE: begin
        if (start && (cmd_t'(command) == CMD_START) && !mzero) begin
          go_mul = 1'b1;
          go_op  = OP_BASE;
        end
      end
      ST_COPY: begin
        if (wlast && (op == OP_BASE)) begin
          go_mul = 1'b1;
          go_op  = OP_ONE;
        end else if (wlast && (op == OP_SQR) && ebit) begin
          go_mul = 1'b1;
          go_op  = OP_MULB;
        end
      end
      ST_EXP: begin
        if (ecnt != '0) begin
          if (started) begin
            go_mul = 1'b1;
            go_op  = OP_SQR;
          end else if (ereg[OPERAND_BITS-1]) begin
            go_mul = 1'b1;
            go_op  = OP_MULB;
          end
        end
      end
      default: begin
        go_mul = 1'b0;
      end
    endcase
  end

  assign m_shift   = (state == ST_MUL);
  assign acc_shift = (state == ST_MUL) || (state == ST_COPY);
  assign b_shift   = acc_shift;
  assign b_ld_one  = go_mul && ((go_op == OP_BASE) || (go_op == OP_ONE));
  assign acc_feed  = (state == ST_COPY) ? {r_word, r_word, r_word}
                                        : {t_word, d1_word, d2_word};
  assign b_feed    = (state == ST_COPY) ? r_word : b_q[0];

  assign ctl.en    = (state == ST_MUL);
  assign ctl.first = (wcnt == '0);
  assign ctl.xbit  = xreg[OPERAND_BITS-1];

  mexp_alu #(.W(W)) u_alu (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .r_word  (r_word),
    .b_word  (b_q[0]),
    .m_word  (m_q[0]),
    .t_word  (t_word),
    .d1_word (d1_word),
    .d2_word (d2_word),
    .sel_out (alu_sel)
  );

  for (genvar k = 0; k < NWORDS; k++) begin : g_ring
    logic [3*W-1:0] acc_din;
    logic [W-1:0]   b_din, m_din;
    logic           m_ld;
    if (k == NWORDS - 1) begin : g_tail
      assign acc_din = acc_feed;
      assign b_din   = b_feed;
      assign m_din   = m_q[0];
    end else begin : g_mid
      assign acc_din = acc_q[k+1];
      assign b_din   = b_q[k+1];
      assign m_din   = m_q[k+1];
    end
    assign m_ld = idle_xfer && (cmd_t'(command) == CMD_LD_MOD) && (k < 16)
                  && (word_index == IDX_W'(k));

    mexp_cell #(.W(3*W)) u_acc (
      .clk (clk), .rst (rst), .shift (acc_shift), .din (acc_din),
      .ld (1'b0), .ld_data ('0), .q (acc_q[k])
    );
    mexp_cell #(.W(W)) u_b (
      .clk (clk), .rst (rst), .shift (b_shift), .din (b_din),
      .ld (b_ld_one), .ld_data ((k == 0) ? W'(1) : W'(0)), .q (b_q[k])
    );
    mexp_cell #(.W(W)) u_m (
      .clk (clk), .rst (rst), .shift (m_shift), .din (m_din),
      .ld (m_ld), .ld_data (word_data[W-1:0]), .q (m_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      op      <= OP_BASE;
      sel     <= SEL_T;
      wcnt    <= '0;
      scnt    <= '0;
      ecnt    <= '0;
      zero    <= 1'b1;
      started <= 1'b0;
      ebit    <= 1'b0;
      err     <= 1'b0;
      for (int k = 0; k < NWORDS; k++) begin
        base_st[k] <= '0;
        exp_st[k]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (cmd_t'(command))
              CMD_LD_BASE: begin
                if (32'(word_index) < NWORDS) base_st[WCW'(word_index)] <= word_data[W-1:0];
              end
              CMD_LD_EXP: begin
                if (32'(word_index) < NWORDS) exp_st[WCW'(word_index)] <= word_data[W-1:0];
              end
              CMD_START: begin
                err     <= mzero;
                started <= 1'b0;
                ecnt    <= ECW'(OPERAND_BITS);
                wcnt    <= '0;
                for (int k = 0; k < NWORDS; k++) ereg[k*W +: W] <= exp_st[k];
                if (mzero) state <= ST_OUT;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MUL: begin
          wcnt <= wlast ? '0 : wcnt + 1'b1;
          if (wlast) begin
            sel  <= alu_sel;
            zero <= 1'b0;
            xreg <= xreg << 1;
            scnt <= scnt + 1'b1;
            if (scnt == SCW'(OPERAND_BITS - 1)) state <= ST_COPY;
          end
        end
        ST_COPY: begin
          if (op == OP_BASE) br[wcnt*W +: W] <= r_word;
          else rf[wcnt] <= r_word;
          wcnt <= wlast ? '0 : wcnt + 1'b1;
          if (wlast) begin
            if (op == OP_MULB) started <= 1'b1;
            state <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (ecnt == '0) begin
            state <= ST_OUT;
            wcnt  <= '0;
          end else begin
            ebit <= ereg[OPERAND_BITS-1];
            ereg <= ereg << 1;
            ecnt <= ecnt - 1'b1;
          end
        end
        ST_OUT: begin
          wcnt <= wlast ? '0 : wcnt + 1'b1;
          if (wlast) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (go_mul) begin
        op    <= go_op;
        state <= ST_MUL;
        zero  <= 1'b1;
        sel   <= SEL_T;
        wcnt  <= '0;
        scnt  <= '0;
        case (go_op)
          OP_BASE: begin
            for (int k = 0; k < NWORDS; k++) xreg[k*W +: W] <= base_st[k];
          end
          OP_ONE:  xreg <= OPERAND_BITS'(1);
          OP_SQR: begin
            for (int k = 0; k < NWORDS; k++) xreg[k*W +: W] <= rf[k];
          end
          OP_MULB: xreg <= br;
          default: xreg <= br;
        endcase
      end
    end
  end

  assign busy         = (state != ST_IDLE);
  assign valid        = (state == ST_OUT);
  assign result_index = IDX_W'(wcnt);
  assign result_data  = err ? '0 : DATA_W'(rf[wcnt]);
  assign last         = valid && wlast;
  assign error        = valid && err;

  a_valid_busy: assert property (@(posedge clk) disable iff (rst) valid |-> busy)
    else $error("result transfer while idle");
  a_last_idle: assert property (@(posedge clk) disable iff (rst) last |=> !busy)
    else $error("still busy after last result");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && error) |-> (result_data == '0))
    else $error("error word not zero");
  a_sel_code: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> (sel == SEL_T || sel == SEL_D1 || sel == SEL_D2))
    else $error("bad reduction select");
  a_first_index: assert property (@(posedge clk) disable iff (rst)
    (valid && !$past(valid)) |-> (result_index == '0))
    else $error("result run does not begin at word zero");

endmodule
